// ===== rtl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

    localparam int unsigned CNT_W = 9;

    localparam logic [15:0]      SUM_INIT       = 16'hFFFF;
    localparam logic [CNT_W-1:0] FRAME_OVERHEAD = 9'd7;
    localparam logic [15:0]      GAP_RESET      = 16'd100;
    localparam logic [CNT_W-1:0] LEN_POS        = 9'd4;
    localparam logic [CNT_W-1:0] HDR_BYTES      = 9'd5;

    localparam logic [1:0] EV_NORMAL   = 2'd0;
    localparam logic [1:0] EV_STALE    = 2'd1;
    localparam logic [1:0] EV_BOGUS    = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] fill_count;
        logic [7:0]       length_byte;
        logic [15:0]      running_sum;
        logic [15:0]      tail_bytes;
        logic [31:0]      last_byte_time;
    } state_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] byte_pos;
        logic             frame_end;
        logic             sum_ok;
        logic [CNT_W-1:0] frame_len;
        logic [1:0]       event_res;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/serial_frame_deframer.sv =====
`default_nettype none

// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+-----------------------------------------------
// in        | in  | in_valid/in_stall  | rx_byte[7:0], now_ms[31:0]
// out       | out | out_valid/out_stall| data_byte, byte_pos, frame_end, sum_ok,
//           |     |                    | frame_len, event_res
// cfg       | in  | cfg_we             | cfg_data[15:0] (gap limit in ms)
//
// One request per cycle sustained while the output does not stall; a request passes the input
// register, then the parser step into the result register, before out_valid rises. The parser
// step itself is combinational logic: a 32-bit subtract and compare for the gap check, a 9-bit
// length add and a 16-bit running-sum subtract. Reset clears the parser state (running sum
// to 0xFFFF), the gap limit to 100 ms and both valid flags. A stall on the output holds the
// result and backs up into in_stall only when the input register is also full.
module serial_frame_deframer #(
    parameter int unsigned BUF_BYTES = 128
) (
    input  wire  logic                     clk,
    input  wire  logic                     rst_n,
    input  wire  logic                     cfg_we,
    input  wire  logic [15:0]              cfg_data,
    input  wire  logic                     in_valid,
    output logic                           in_stall,
    input  wire  logic [7:0]               rx_byte,
    input  wire  logic [31:0]              now_ms,
    output logic                           out_valid,
    input  wire  logic                     out_stall,
    output logic [7:0]                     data_byte,
    output logic [sfd_pkg::CNT_W-1:0]      byte_pos,
    output logic                           frame_end,
    output logic                           sum_ok,
    output logic [sfd_pkg::CNT_W-1:0]      frame_len,
    output logic [1:0]                     event_res
);
    import sfd_pkg::*;

    localparam logic [CNT_W-1:0] BufLen = CNT_W'(BUF_BYTES);

    logic [15:0] gap_limit_reg;

    // input register
    logic        in_vld_reg;
    logic        in_vld_next;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_time_reg;

    // parser state
    state_t      state_reg;
    state_t      state_next;

    // result register
    logic        res_vld_reg;
    logic        res_vld_next;
    result_t     res_reg;
    result_t     res_next;

    logic        in_take;
    logic        advance;
    logic        fire;

    // the result slot frees when empty or when it is being taken this cycle
    assign advance  = !res_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign fire     = in_vld_reg && advance;

    sfd_step #(
        .BUF_BYTES (BUF_BYTES)
    ) u_step (
        .state_cur (state_reg),
        .gap_limit (gap_limit_reg),
        .rx_byte   (in_byte_reg),
        .now_ms    (in_time_reg),
        .state_nxt (state_next),
        .res       (res_next)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        res_vld_next = res_vld_reg;
        if (advance)
            res_vld_next = in_vld_reg;
    end

    // control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg            <= GAP_RESET;
            in_vld_reg               <= 1'b0;
            res_vld_reg              <= 1'b0;
            state_reg.fill_count     <= '0;
            state_reg.length_byte    <= '0;
            state_reg.running_sum    <= SUM_INIT;
            state_reg.tail_bytes     <= '0;
            state_reg.last_byte_time <= '0;
        end
        else
        begin
            if (cfg_we)
                gap_limit_reg <= cfg_data;
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
            // advance the parser only when a byte moves into the result slot
            if (fire)
                state_reg <= state_next;
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
            in_time_reg <= now_ms;
        end
        if (fire)
            res_reg <= res_next;
    end

    assign out_valid = res_vld_reg;
    assign data_byte = res_reg.data_byte;
    assign byte_pos  = res_reg.byte_pos;
    assign frame_end = res_reg.frame_end;
    assign sum_ok    = res_reg.sum_ok;
    assign frame_len = res_reg.frame_len;
    assign event_res = res_reg.event_res;

    // a completed frame always reports a length of at least the overhead, nothing else does
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_end ? (frame_len >= FRAME_OVERHEAD) :
                                   (frame_len == '0 && !sum_ok)))
        else $error("frame_len/sum_ok inconsistent with frame_end");

    // a dropped length never completes a frame
    a_bogus_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_BOGUS) |-> !frame_end)
        else $error("bogus length reported together with frame end");

    // positions stay inside the buffer
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_pos < BufLen))
        else $error("byte_pos outside buffer");

    // parser state changes only when a byte is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("parser state changed without a byte");

    // the input register drains whenever the result slot is free and no new byte is taken
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && advance && !in_take |=> !in_vld_reg)
        else $error("input register failed to drain");

endmodule

`default_nettype wire

// ===== rtl/sfd_step.sv =====
`default_nettype none

// Per-byte parser step: current state plus one byte gives next state and result.
module sfd_step #(
    parameter int unsigned BUF_BYTES = 128
) (
    input  wire sfd_pkg::state_t  state_cur,
    input  wire logic [15:0]      gap_limit,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [31:0]      now_ms,
    output sfd_pkg::state_t       state_nxt,
    output sfd_pkg::result_t      res
);
    import sfd_pkg::*;

    localparam logic [CNT_W-1:0] BufLen = CNT_W'(BUF_BYTES);

    logic [31:0]      gap;
    logic             stale;
    logic [CNT_W-1:0] fill_a;
    logic             ovf;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] fill_inc;
    logic [15:0]      sum_base;
    logic [15:0]      tail_base;
    logic [7:0]       len_now;
    logic [CNT_W-1:0] expected;
    logic [CNT_W:0]   pos_plus2;

    always_comb
    begin
        gap    = now_ms - state_cur.last_byte_time;
        stale  = (state_cur.fill_count != '0) && (gap > {16'd0, gap_limit});
        fill_a = stale ? '0 : state_cur.fill_count;
        ovf    = (fill_a >= BufLen);
        pos    = ovf ? '0 : fill_a;

        sum_base  = (pos == '0) ? SUM_INIT : state_cur.running_sum;
        tail_base = (pos == '0) ? 16'd0 : state_cur.tail_bytes;
        len_now   = (pos == LEN_POS) ? rx_byte : state_cur.length_byte;
        fill_inc  = pos + 1'b1;
        expected  = {1'b0, len_now} + FRAME_OVERHEAD;
        pos_plus2 = {1'b0, pos} + 10'd2;

        state_nxt.fill_count     = fill_inc;
        state_nxt.length_byte    = len_now;
        state_nxt.running_sum    = sum_base;
        state_nxt.tail_bytes     = {tail_base[7:0], rx_byte};
        state_nxt.last_byte_time = now_ms;

        res.data_byte = rx_byte;
        res.byte_pos  = pos;
        res.frame_end = 1'b0;
        res.sum_ok    = 1'b0;
        res.frame_len = '0;
        res.event_res = ovf ? EV_OVERFLOW : (stale ? EV_STALE : EV_NORMAL);

        if (fill_inc < HDR_BYTES)
        begin
            state_nxt.running_sum = sum_base - {8'd0, rx_byte};
        end
        else if (expected > BufLen)
        begin
            // drop the frame: length cannot fit the buffer
            state_nxt.fill_count = '0;
            res.event_res        = EV_BOGUS;
        end
        else
        begin
            if (pos_plus2 < {1'b0, expected})
                state_nxt.running_sum = sum_base - {8'd0, rx_byte};
            if (fill_inc == expected)
            begin
                res.frame_end        = 1'b1;
                res.sum_ok           = (state_nxt.tail_bytes == state_nxt.running_sum);
                res.frame_len        = expected;
                state_nxt.fill_count = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/serial_frame_deframer_tb.sv =====
// Tracks the frame the block should be parsing and holds the results it owes.
class frame_scoreboard #(int unsigned BUF = 128);

    logic [15:0]       gap_limit;
    logic [8:0]        fill;
    logic [7:0]        len_byte;
    logic [15:0]       run_sum;
    logic [15:0]       tail;
    logic [31:0]       last_time;
    sfd_pkg::result_t  owed_q[$];
    int unsigned       errors;
    int unsigned       results_seen;

    function new();
        gap_limit    = sfd_pkg::GAP_RESET;
        fill         = '0;
        len_byte     = '0;
        run_sum      = sfd_pkg::SUM_INIT;
        tail         = '0;
        last_time    = '0;
        errors       = 0;
        results_seen = 0;
    endfunction

    function void set_gap_limit(logic [15:0] value);
        gap_limit = value;
    endfunction

    function bit frame_open();
        return fill != '0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    function void report_mismatch(string msg);
        errors++;
        $display("MISMATCH [%0t] %s", $time, msg);
    endfunction

    // Advance the parser by one accepted request and queue the result it owes.
    function void note_request(logic [7:0] b, logic [31:0] now);
        sfd_pkg::result_t want;
        logic [31:0]      elapsed;
        logic [8:0]       pos;
        logic [8:0]       frame_total;
        want           = '0;
        want.data_byte = b;
        want.event_res = sfd_pkg::EV_NORMAL;
        elapsed        = now - last_time;
        if (fill != '0 && elapsed > {16'd0, gap_limit})
        begin
            fill           = '0;
            want.event_res = sfd_pkg::EV_STALE;
        end
        last_time = now;
        if (fill >= BUF)
        begin
            fill           = '0;
            want.event_res = sfd_pkg::EV_OVERFLOW;
        end
        pos = fill;
        if (pos == '0)
        begin
            run_sum = sfd_pkg::SUM_INIT;
            tail    = '0;
        end
        if (pos == sfd_pkg::LEN_POS)
            len_byte = b;
        fill = pos + 9'd1;
        tail = {tail[7:0], b};
        if (fill < sfd_pkg::HDR_BYTES)
            run_sum = run_sum - {8'd0, b};
        else
        begin
            frame_total = {1'b0, len_byte} + sfd_pkg::FRAME_OVERHEAD;
            if (frame_total > BUF)
            begin
                fill           = '0;
                want.event_res = sfd_pkg::EV_BOGUS;
            end
            else
            begin
                // the two trailing checksum bytes stay out of the sum
                if (pos + 9'd2 < frame_total)
                    run_sum = run_sum - {8'd0, b};
                if (fill == frame_total)
                begin
                    want.frame_end = 1'b1;
                    want.sum_ok    = (tail == run_sum);
                    want.frame_len = frame_total;
                    fill           = '0;
                end
            end
        end
        want.byte_pos = pos;
        owed_q.insert(owed_q.size(), want);
    endfunction

    function void check_result(sfd_pkg::result_t got);
        sfd_pkg::result_t want;
        results_seen++;
        if (owed_q.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with no request pending",
                                      results_seen));
            return;
        end
        want = owed_q.pop_front();
        if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("result %0d data_byte got %0h want %0h",
                                      results_seen, got.data_byte, want.data_byte));
        if (got.byte_pos !== want.byte_pos)
            report_mismatch($sformatf("result %0d byte_pos got %0d want %0d",
                                      results_seen, got.byte_pos, want.byte_pos));
        if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("result %0d frame_end got %0b want %0b",
                                      results_seen, got.frame_end, want.frame_end));
        if (got.sum_ok !== want.sum_ok)
            report_mismatch($sformatf("result %0d sum_ok got %0b want %0b",
                                      results_seen, got.sum_ok, want.sum_ok));
        if (got.frame_len !== want.frame_len)
            report_mismatch($sformatf("result %0d frame_len got %0d want %0d",
                                      results_seen, got.frame_len, want.frame_len));
        if (got.event_res !== want.event_res)
            report_mismatch($sformatf("result %0d event_res got %0d want %0d",
                                      results_seen, got.event_res, want.event_res));
    endfunction

endclass

module serial_frame_deframer_tb;

    import sfd_pkg::*;

    localparam int unsigned FRAME_BUF    = 128;
    localparam int unsigned STALL_PCT    = 36;    // idle share of each side, in percent
    localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned OPENING      = 27;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [15:0]         cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [7:0]          rx_byte   = '0;
    logic [31:0]         now_ms    = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [7:0]          data_byte;
    logic [CNT_W-1:0]    byte_pos;
    logic                frame_end;
    logic                sum_ok;
    logic [CNT_W-1:0]    frame_len;
    logic [1:0]          event_res;
    result_t             out_result;

    frame_scoreboard #(FRAME_BUF) sb;

    // Stimulus-side view of the link: last arrival time and the active gap limit.
    logic [31:0]         clock_ms     = '0;
    logic [15:0]         cur_gap      = GAP_RESET;
    bit                  steady       = 1'b0;
    int unsigned         items_sent   = 0;
    int unsigned         quiet_cycles = 0;

    // Opening directed run: bytes and the ms that pass before each one.
    //  - shortest frame with a good checksum, timestamps wrapping through zero
    //  - shortest frame with a bad checksum, each byte exactly at the gap limit
    //  - a partial frame that goes quiet one ms past the limit
    //  - the first over-size length (122), then the largest length byte (255)
    logic [7:0] opening_bytes [OPENING] = '{
        8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFE, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFE,
        8'h12, 8'h34, 8'h56, 8'hAB,
        8'h01, 8'h02, 8'h03, 8'h7A,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };
    int unsigned opening_gaps [OPENING] = '{
        0, 1, 1, 1, 1, 1, 1,
        100, 100, 100, 100, 100, 100, 100,
        5, 5, 5, 101,
        1, 1, 1, 1,
        0, 0, 0, 0, 0
    };

    serial_frame_deframer #(
        .BUF_BYTES (FRAME_BUF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_byte (data_byte),
        .byte_pos  (byte_pos),
        .frame_end (frame_end),
        .sum_ok    (sum_ok),
        .frame_len (frame_len),
        .event_res (event_res)
    );

    assign out_result = {data_byte, byte_pos, frame_end, sum_ok, frame_len, event_res};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check each accepted result, then pick the stall for the next cycle.
    // All block outputs and out_stall change only through nonblocking updates, so the
    // values read here are the ones that held at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_result);
        out_stall <= !steady && ($urandom_range(0, 99) < STALL_PCT);
    end

    // Watchdog: give up once no request or result has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Pick a time step that keeps the current frame alive; hit the limit itself often.
    function automatic logic [31:0] calm_delta();
        if ($urandom_range(0, 3) == 0)
            return {16'd0, cur_gap};
        return $urandom_range(0, cur_gap);
    endfunction

    // Pick a time step that makes any partial frame stale; often just one ms over.
    function automatic logic [31:0] stale_delta();
        if ($urandom_range(0, 1) == 0)
            return {16'd0, cur_gap} + 32'd1;
        return {16'd0, cur_gap} + 32'd1 + $urandom_range(0, 5000);
    endfunction

    // Flush a leftover partial frame so the next frame lines up; otherwise jump anywhere.
    function automatic logic [31:0] frame_start_delta();
        if (sb.frame_open())
            return stale_delta();
        if ($urandom_range(0, 2) == 0)
            return $urandom();
        return calm_delta();
    endfunction

    // Offer one request, idling first at random, and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic [31:0] delta);
        logic [31:0] stamp;
        stamp = clock_ms + delta;
        while (!steady && $urandom_range(0, 99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        now_ms   <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(b, stamp);
        clock_ms = stamp;
        items_sent++;
    endtask

    // Send a frame with the given length byte, stopping after `cut` bytes.
    // Over-size lengths are dropped by the block after the length byte.
    task automatic send_frame(input int unsigned len, input bit good_sum,
                              input int unsigned cut);
        logic [15:0] sum;
        logic [15:0] chk;
        logic [15:0] flip;
        logic [7:0]  b;
        int unsigned total;
        total = len + 7;
        sum   = '0;
        chk   = '0;
        flip  = good_sum ? 16'd0 : (16'd1 << $urandom_range(0, 15));
        for (int i = 0; i < total && i < cut; i++)
        begin
            if (i == total - 2)
                chk = (SUM_INIT - sum) ^ flip;
            if (i == LEN_POS)
                b = len[7:0];
            else if (i == total - 2)
                b = chk[15:8];
            else if (i == total - 1)
                b = chk[7:0];
            else
                b = 8'($urandom_range(0, 255));
            if (i < total - 2)
                sum = sum + {8'd0, b};
            send_byte(b, (i == 0) ? frame_start_delta() : calm_delta());
        end
    endtask

    // Drain every owed result, let the pipeline settle, then load a new gap limit.
    task automatic write_gap_limit(input logic [15:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_gap_limit(value);
        cur_gap = value;
    endtask

    initial
    begin
        logic [15:0] gap_plan [PHASES];
        int unsigned phase_end;
        int unsigned pick;
        int unsigned len;
        sb = new();
        gap_plan = '{GAP_RESET, 16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)),
                     16'd1, 16'($urandom_range(2, 65534))};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, run on the gap limit left by reset.
        clock_ms = 32'hFFFF_FFFC;
        for (int i = 0; i < OPENING; i++)
            send_byte(opening_bytes[i], opening_gaps[i]);

        // Open the random part with the longest legal frame.
        send_frame(FRAME_BUF - 7, 1'b1, FRAME_BUF);

        // Random part, one gap limit per phase; the third phase never idles.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
                write_gap_limit(gap_plan[phase]);
            steady    = (phase == 2);
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 24) == 0) ? $urandom_range(100, FRAME_BUF - 7)
                                                    : $urandom_range(0, 16);
                if (pick < 70)
                    send_frame(len, $urandom_range(0, 9) != 0, FRAME_BUF);
                else if (pick < 80)
                    send_frame(len, 1'b1, $urandom_range(1, len + 6));
                else if (pick < 90)
                    send_frame($urandom_range(FRAME_BUF - 6, 255), 1'b1,
                               $urandom_range(5, 7));
                else
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom_range(0, 255)),
                                  $urandom_range(0, 1) ? $urandom() : calm_delta());
            end
        end

        // Drain, then keep clocking so the pipeline can show any stray result.
        in_valid <= 1'b0;
        steady    = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== serial_frame_deframer.f =====
rtl/sfd_pkg.sv
rtl/sfd_step.sv
rtl/serial_frame_deframer.sv
tb/serial_frame_deframer_tb.sv
